[hdl/mbvs_pkg.sv]
// shared types, constants and helpers for the monochrome bitmap scroll engine
`default_nettype none

package mbvs_pkg;

    localparam int MAX_ROW_BYTES = 128;
    localparam int MAX_ROWS      = 1024;
    localparam int MEM_DEPTH     = MAX_ROW_BYTES * MAX_ROWS;
    localparam int MEM_AW        = $clog2(MEM_DEPTH);

    // configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 10;

    localparam logic [CFG_AW-1:0] REG_ROW_BYTES   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_CLIP_LEFT   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_CLIP_TOP    = 3'd2;
    localparam logic [CFG_AW-1:0] REG_CLIP_RIGHT  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_CLIP_BOTTOM = 3'd4;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_SCROLL = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // stream widths
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_EXEC   = 11'b000_0000_0010,
        ST_RDWAIT = 11'b000_0000_0100,
        ST_CLIPB  = 11'b000_0000_1000,
        ST_CLIPC  = 11'b000_0001_0000,
        ST_MULS   = 11'b000_0010_0000,
        ST_MULD   = 11'b000_0100_0000,
        ST_RSRC   = 11'b000_1000_0000,
        ST_RDST   = 11'b001_0000_0000,
        ST_WR     = 11'b010_0000_0000,
        ST_FINISH = 11'b100_0000_0000
    } state_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    // pixel mask for one byte, msb is the leftmost pixel
    function automatic logic [7:0] edge_mask(input logic [2:0] lo, input logic [2:0] hi);
        logic [7:0] left_part;
        logic [7:0] right_part;
        left_part  = 8'hFF >> lo;
        right_part = 8'hFF << (3'd7 - hi);
        return left_part & right_part;
    endfunction

endpackage

`default_nettype wire

[hdl/mbvs_frame_mem.sv]
// single-port frame buffer memory with registered read data
`default_nettype none

module mbvs_frame_mem (
    input  wire logic              aclk,
    input  wire mbvs_pkg::mem_req_t req,
    output logic [7:0]             rdata
);

    logic [7:0] mem [mbvs_pkg::MEM_DEPTH];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re) begin
            rdata <= mem[req.addr];
        end
    end

endmodule

`default_nettype wire

[hdl/mono_bitmap_vertical_scroll.sv]
// top level: 1 bpp frame buffer with byte access and a vertical scroll engine
// scroll: each byte is a read-modify-write through the single frame buffer port
//   (read source, read destination, write)
// throughput: one transaction at a time; s_tready is high only while the sequencer is idle
// reset: aresetn low clears the sequencer, output valid and config registers to their
//   defaults; the frame buffer is not cleared and holds no valid bits
`default_nettype none

module mono_bitmap_vertical_scroll (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration write port
    input  wire logic                             cfg_wen,
    input  wire logic [mbvs_pkg::CFG_AW-1:0]      cfg_addr,
    input  wire logic [mbvs_pkg::CFG_DW-1:0]      cfg_wdata,
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // mode[1:0], byte_addr[18:2], write_data[26:19], src_x[36:27], src_y[46:37],
    // rect_width[57:47], rect_height[68:58], dst_y[78:69], zero[79]
    input  wire logic [mbvs_pkg::S_TDATA_W-1:0]   s_tdata,
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // read_data[7:0], skipped[8], zero[15:9]
    output logic [mbvs_pkg::M_TDATA_W-1:0]        m_tdata
);

    localparam int AW = mbvs_pkg::MEM_AW;

    // configuration registers
    logic [7:0] row_bytes_reg;
    logic [9:0] clip_left_reg, clip_top_reg, clip_right_reg, clip_bottom_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_bytes_reg   <= 8'd80;
            clip_left_reg   <= 10'd0;
            clip_top_reg    <= 10'd0;
            clip_right_reg  <= 10'd1023;
            clip_bottom_reg <= 10'd1023;
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                mbvs_pkg::REG_ROW_BYTES:   row_bytes_reg   <= cfg_wdata[7:0];
                mbvs_pkg::REG_CLIP_LEFT:   clip_left_reg   <= cfg_wdata;
                mbvs_pkg::REG_CLIP_TOP:    clip_top_reg    <= cfg_wdata;
                mbvs_pkg::REG_CLIP_RIGHT:  clip_right_reg  <= cfg_wdata;
                mbvs_pkg::REG_CLIP_BOTTOM: clip_bottom_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer state
    mbvs_pkg::state_t state_reg, state_next;

    // latched transaction fields
    logic [1:0]    mode_reg;
    logic [16:0]   addr_reg;
    logic [7:0]    wdata_reg;
    logic [9:0]    x0_reg, y0_reg, y1_reg;
    logic [10:0]   w_reg, h_reg;

    // clipping and copy working registers
    logic [9:0]         xl_reg, xr_reg, dpos_reg;
    logic               trivial_reg, empty_x_reg;
    logic [11:0]        y0p_reg, y1p_reg;
    logic signed [12:0] hp_reg;
    logic [9:0]         sy_reg, dy_reg;
    logic               up_reg;
    logic [10:0]        rows_left_reg;
    logic [AW-1:0]      sbase_reg, dbase_reg;
    logic [6:0]         b_reg;
    logic [7:0]         src_reg;
    logic [7:0]         res_rd_reg;
    logic               res_sk_reg;

    // output register
    logic               m_valid_reg;
    logic [7:0]         m_rd_reg;
    logic               m_sk_reg;

    logic               s_accept;
    logic               out_free;

    assign s_tready = (state_reg == mbvs_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_sk_reg, m_rd_reg};

    // frame buffer
    mbvs_pkg::mem_req_t mem_req;
    logic [7:0]         mem_rdata;

    mbvs_frame_mem u_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // column clip, first step of the row clip
    logic signed [12:0] x_end;
    logic [9:0]         xl_c;
    logic signed [12:0] xr_c;
    logic [9:0]         ymin_c;
    logic signed [12:0] d_c;

    always_comb begin
        xl_c   = (x0_reg < clip_left_reg) ? clip_left_reg : x0_reg;
        x_end  = $signed({3'd0, x0_reg}) + $signed({2'd0, w_reg}) - 13'sd1;
        xr_c   = (x_end > $signed({3'd0, clip_right_reg})) ?
                 $signed({3'd0, clip_right_reg}) : x_end;
        ymin_c = (y0_reg < y1_reg) ? y0_reg : y1_reg;
        d_c    = $signed({3'd0, clip_top_reg}) - $signed({3'd0, ymin_c});
    end

    // final row clip
    logic [11:0]        ymax_c;
    logic signed [12:0] lim_c, hf_c;
    logic               empty_c;
    logic               up_c;
    logic [9:0]         off_c;

    always_comb begin
        ymax_c  = (y0p_reg > y1p_reg) ? y0p_reg : y1p_reg;
        lim_c   = $signed({3'd0, clip_bottom_reg}) - $signed({1'b0, ymax_c}) + 13'sd1;
        hf_c    = (hp_reg < lim_c) ? hp_reg : lim_c;
        empty_c = trivial_reg || empty_x_reg || (hf_c <= 13'sd0);
        up_c    = (y1_reg < y0_reg);
        off_c   = up_c ? 10'd0 : hf_c[9:0] - 10'd1;
    end

    // shared multiplier for row base addresses
    logic [9:0]  mul_a;
    logic [17:0] mul_p;

    assign mul_a = (state_reg == mbvs_pkg::ST_MULD) ? dy_reg : sy_reg;
    assign mul_p = mul_a * row_bytes_reg;

    // per-byte addressing and merge
    logic [AW-1:0] src_addr, dst_addr;
    logic [2:0]    lo_c, hi_c;
    logic [7:0]    mask_c;
    logic          last_byte;

    always_comb begin
        src_addr  = sbase_reg + {{(AW-7){1'b0}}, b_reg};
        dst_addr  = dbase_reg + {{(AW-7){1'b0}}, b_reg};
        lo_c      = (b_reg == xl_reg[9:3]) ? xl_reg[2:0] : 3'd0;
        hi_c      = (b_reg == xr_reg[9:3]) ? xr_reg[2:0] : 3'd7;
        mask_c    = mbvs_pkg::edge_mask(lo_c, hi_c);
        last_byte = (b_reg == xr_reg[9:3]);
    end

    // memory requests
    always_comb begin
        mem_req = '0;
        unique case (state_reg)
            mbvs_pkg::ST_EXEC: begin
                mem_req.addr  = addr_reg[AW-1:0];
                mem_req.wdata = wdata_reg;
                mem_req.we    = (mode_reg == mbvs_pkg::MODE_WRITE);
                mem_req.re    = (mode_reg == mbvs_pkg::MODE_READ);
            end
            mbvs_pkg::ST_RSRC: begin
                mem_req.addr = src_addr;
                mem_req.re   = 1'b1;
            end
            mbvs_pkg::ST_RDST: begin
                mem_req.addr = dst_addr;
                mem_req.re   = 1'b1;
            end
            mbvs_pkg::ST_WR: begin
                mem_req.addr  = dst_addr;
                mem_req.we    = 1'b1;
                mem_req.wdata = (mem_rdata & ~mask_c) | (src_reg & mask_c);
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mbvs_pkg::ST_IDLE:   if (s_accept) state_next = mbvs_pkg::ST_EXEC;
            mbvs_pkg::ST_EXEC: begin
                unique case (mode_reg)
                    mbvs_pkg::MODE_READ:   state_next = mbvs_pkg::ST_RDWAIT;
                    mbvs_pkg::MODE_SCROLL: state_next = mbvs_pkg::ST_CLIPB;
                    default:               state_next = mbvs_pkg::ST_FINISH;
                endcase
            end
            mbvs_pkg::ST_RDWAIT: state_next = mbvs_pkg::ST_FINISH;
            mbvs_pkg::ST_CLIPB:  state_next = mbvs_pkg::ST_CLIPC;
            mbvs_pkg::ST_CLIPC:  state_next = empty_c ? mbvs_pkg::ST_FINISH : mbvs_pkg::ST_MULS;
            mbvs_pkg::ST_MULS:   state_next = mbvs_pkg::ST_MULD;
            mbvs_pkg::ST_MULD:   state_next = mbvs_pkg::ST_RSRC;
            mbvs_pkg::ST_RSRC:   state_next = mbvs_pkg::ST_RDST;
            mbvs_pkg::ST_RDST:   state_next = mbvs_pkg::ST_WR;
            mbvs_pkg::ST_WR: begin
                if (!last_byte) begin
                    state_next = mbvs_pkg::ST_RSRC;
                end else if (rows_left_reg == 11'd1) begin
                    state_next = mbvs_pkg::ST_FINISH;
                end else begin
                    state_next = mbvs_pkg::ST_MULS;
                end
            end
            mbvs_pkg::ST_FINISH: if (out_free) state_next = mbvs_pkg::ST_IDLE;
            default:             state_next = mbvs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mbvs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg  <= s_tdata[1:0];
            addr_reg  <= s_tdata[18:2];
            wdata_reg <= s_tdata[26:19];
            x0_reg    <= s_tdata[36:27];
            y0_reg    <= s_tdata[46:37];
            w_reg     <= s_tdata[57:47];
            h_reg     <= s_tdata[68:58];
            y1_reg    <= s_tdata[78:69];
        end
        unique case (state_reg)
            mbvs_pkg::ST_EXEC: begin
                res_rd_reg  <= 8'd0;
                res_sk_reg  <= 1'b0;
                xl_reg      <= xl_c;
                xr_reg      <= xr_c[9:0];
                empty_x_reg <= (xr_c < $signed({3'd0, xl_c}));
                trivial_reg <= (y0_reg == y1_reg) || (w_reg == 11'd0);
                dpos_reg    <= (d_c > 13'sd0) ? d_c[9:0] : 10'd0;
            end
            mbvs_pkg::ST_RDWAIT: begin
                res_rd_reg <= mem_rdata;
            end
            mbvs_pkg::ST_CLIPB: begin
                y0p_reg <= {2'd0, y0_reg} + {2'd0, dpos_reg};
                y1p_reg <= {2'd0, y1_reg} + {2'd0, dpos_reg};
                hp_reg  <= $signed({2'd0, h_reg}) - $signed({3'd0, dpos_reg});
            end
            mbvs_pkg::ST_CLIPC: begin
                // nothing left after clipping reports skipped
                res_sk_reg    <= empty_c;
                up_reg        <= up_c;
                rows_left_reg <= hf_c[10:0];
                sy_reg        <= y0p_reg[9:0] + off_c;
                dy_reg        <= y1p_reg[9:0] + off_c;
            end
            mbvs_pkg::ST_MULS: begin
                sbase_reg <= mul_p[AW-1:0];
                b_reg     <= xl_reg[9:3];
            end
            mbvs_pkg::ST_MULD: begin
                dbase_reg <= mul_p[AW-1:0];
            end
            mbvs_pkg::ST_RDST: begin
                src_reg <= mem_rdata;
            end
            mbvs_pkg::ST_WR: begin
                if (!last_byte) begin
                    b_reg <= b_reg + 7'd1;
                end else begin
                    // next row: downward when moving up, upward when moving down
                    rows_left_reg <= rows_left_reg - 11'd1;
                    sy_reg        <= up_reg ? sy_reg + 10'd1 : sy_reg - 10'd1;
                    dy_reg        <= up_reg ? dy_reg + 10'd1 : dy_reg - 10'd1;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == mbvs_pkg::ST_FINISH && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == mbvs_pkg::ST_FINISH && out_free) begin
            m_rd_reg <= res_rd_reg;
            m_sk_reg <= res_sk_reg;
        end
    end

    // checks
    logic in_copy;
    assign in_copy = (state_reg == mbvs_pkg::ST_RSRC) || (state_reg == mbvs_pkg::ST_RDST) ||
                     (state_reg == mbvs_pkg::ST_WR);

    a_rows_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        in_copy |-> (rows_left_reg != 11'd0))
        else $error("copy running with no rows left");

    a_byte_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        in_copy |-> (b_reg >= xl_reg[9:3] && b_reg <= xr_reg[9:3]))
        else $error("byte index outside clipped span");

    a_skip_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_sk_reg && m_rd_reg != 8'd0))
        else $error("skipped result carries read data");

    a_write_only_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.we |-> (state_reg == mbvs_pkg::ST_WR || state_reg == mbvs_pkg::ST_EXEC))
        else $error("frame buffer write outside write states");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == mbvs_pkg::ST_EXEC))
        else $error("accepted transaction not started");

endmodule

`default_nettype wire

[sim/mono_bitmap_vertical_scroll_tb.sv]
// self-checking testbench for the monochrome bitmap vertical scroll engine
module mono_bitmap_vertical_scroll_tb;

    localparam int STALL_LIMIT = 4000;   // cycles with no transaction before giving up
    localparam int SETTLE      = 20;     // quiet cycles after the last result

    // one request on the input stream
    typedef struct {
        logic [1:0]  mode;
        logic [16:0] byte_addr;
        logic [7:0]  write_data;
        logic [9:0]  src_x;
        logic [9:0]  src_y;
        logic [10:0] rect_width;
        logic [10:0] rect_height;
        logic [9:0]  dst_y;
    } fb_request_t;

    typedef struct {
        logic [7:0] read_data;
        logic       skipped;
    } fb_result_t;

    // mirror of the frame buffer and clip registers, predicts every result
    class bitmap_mirror;
        logic [7:0]  frame [mbvs_pkg::MEM_DEPTH];
        bit          written [mbvs_pkg::MEM_DEPTH];
        int unsigned pitch;
        int          clip_l, clip_t, clip_r, clip_b;
        fb_result_t  pending_results [$];
        int          errors, n_writes, n_reads, n_copied, n_skipped, n_unused;

        function new();
            pitch  = 80;
            clip_l = 0;
            clip_t = 0;
            clip_r = 1023;
            clip_b = 1023;
        endfunction

        function void set_register(logic [mbvs_pkg::CFG_AW-1:0] idx,
                                   logic [mbvs_pkg::CFG_DW-1:0] val);
            case (idx)
                mbvs_pkg::REG_ROW_BYTES:   pitch  = val[7:0];
                mbvs_pkg::REG_CLIP_LEFT:   clip_l = val;
                mbvs_pkg::REG_CLIP_TOP:    clip_t = val;
                mbvs_pkg::REG_CLIP_RIGHT:  clip_r = val;
                mbvs_pkg::REG_CLIP_BOTTOM: clip_b = val;
                default: ;
            endcase
        endfunction

        function int unsigned row_addr(int y, int col_byte);
            return (y * pitch + col_byte) % mbvs_pkg::MEM_DEPTH;
        endfunction

        // merge one row span into the destination row under the edge masks
        function void move_row(int sy, int dy, int xl, int xr);
            int          b, base, lo, hi;
            logic [7:0]  mask;
            int unsigned sa, da;
            for (b = xl >> 3; b <= (xr >> 3); b++) begin
                base = b * 8;
                lo   = (xl > base ? xl : base) - base;
                hi   = (xr < base + 7 ? xr : base + 7) - base;
                mask = (8'hFF >> lo) & (8'hFF << (7 - hi));
                sa   = row_addr(sy, b);
                da   = row_addr(dy, b);
                frame[da] = (frame[da] & ~mask) | (frame[sa] & mask);
            end
        endfunction

        // returns 1 when the scroll ends up doing nothing
        function bit scroll_rows(int x0, int y0, int w, int h, int y1);
            int d, lim, i, r;
            if (y0 == y1 || w == 0) return 1'b1;
            if (x0 < clip_l) begin
                w  -= clip_l - x0;
                x0  = clip_l;
            end
            if (x0 + w - 1 > clip_r) w = clip_r - x0 + 1;
            // shift both rectangles down until both start inside the window
            d = 0;
            if (clip_t - y0 > d) d = clip_t - y0;
            if (clip_t - y1 > d) d = clip_t - y1;
            y0 += d;
            y1 += d;
            h  -= d;
            lim = clip_b - y0 + 1;
            if (clip_b - y1 + 1 < lim) lim = clip_b - y1 + 1;
            if (h > lim) h = lim;
            if (w <= 0 || h <= 0) return 1'b1;
            // top-down when moving up, bottom-up when moving down
            for (i = 0; i < h; i++) begin
                r = (y1 < y0) ? i : h - 1 - i;
                move_row(y0 + r, y1 + r, x0, x0 + w - 1);
            end
            return 1'b0;
        endfunction

        function void note_request(fb_request_t q);
            fb_result_t e;
            e.read_data = 8'h00;
            e.skipped   = 1'b0;
            case (q.mode)
                mbvs_pkg::MODE_WRITE: begin
                    frame[q.byte_addr]   = q.write_data;
                    written[q.byte_addr] = 1'b1;
                    n_writes++;
                end
                mbvs_pkg::MODE_READ: begin
                    e.read_data = frame[q.byte_addr];
                    n_reads++;
                end
                mbvs_pkg::MODE_SCROLL: begin
                    e.skipped = scroll_rows(int'(q.src_x), int'(q.src_y), int'(q.rect_width),
                                            int'(q.rect_height), int'(q.dst_y));
                    if (e.skipped) n_skipped++;
                    else n_copied++;
                end
                default: n_unused++;
            endcase
            pending_results.push_back(e);
        endfunction

        function void check_result(logic [mbvs_pkg::M_TDATA_W-1:0] beat);
            fb_result_t e;
            if (pending_results.size() == 0) begin
                $display("%0t: result %04h with nothing expected", $time, beat);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (beat[7:0] !== e.read_data) begin
                $display("%0t: read_data expected %02h actual %02h", $time, e.read_data,
                         beat[7:0]);
                errors++;
            end
            if (beat[8] !== e.skipped) begin
                $display("%0t: skipped expected %0b actual %0b", $time, e.skipped, beat[8]);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            cfg_wen;
    logic [mbvs_pkg::CFG_AW-1:0]     cfg_addr;
    logic [mbvs_pkg::CFG_DW-1:0]     cfg_wdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [mbvs_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [mbvs_pkg::M_TDATA_W-1:0]  m_tdata;

    bitmap_mirror mirror;
    int unsigned  written_list [$];   // addresses that are safe to read back
    int           cur_pitch, cur_left, cur_top, cur_right, cur_bottom;
    int           s_calm, m_calm;     // remaining items of a stretch without idling
    int           idle_cycles;

    mono_bitmap_vertical_scroll dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // per-item wait, with occasional stretches of back-to-back traffic
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm_left = $urandom_range(4, 16);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    function automatic fb_request_t make_request(logic [1:0] mode, int addr, int data,
                                                 int sx, int sy, int w, int h, int dy);
        fb_request_t q;
        q.mode        = mode;
        q.byte_addr   = 17'(addr);
        q.write_data  = 8'(data);
        q.src_x       = 10'(sx);
        q.src_y       = 10'(sy);
        q.rect_width  = 11'(w);
        q.rect_height = 11'(h);
        q.dst_y       = 10'(dy);
        return q;
    endfunction

    // every field random over its full range; callers override what matters
    function automatic fb_request_t random_fields();
        return make_request(2'($urandom_range(0, 3)),
                            $urandom_range(0, mbvs_pkg::MEM_DEPTH - 1),
                            $urandom_range(0, 255), $urandom_range(0, 1023),
                            $urandom_range(0, 1023), $urandom_range(0, 1024),
                            $urandom_range(0, 1024), $urandom_range(0, 1023));
    endfunction

    function automatic logic [mbvs_pkg::S_TDATA_W-1:0] pack_request(fb_request_t q);
        return {1'b0, q.dst_y, q.rect_height, q.rect_width, q.src_y, q.src_x,
                q.write_data, q.byte_addr, q.mode};
    endfunction

    // value a little around [lo, hi], kept inside the 10-bit coordinate range
    function automatic int near_range(int lo, int hi);
        int a, b;
        a = (lo < hi ? lo : hi) - 6;
        b = (lo < hi ? hi : lo) + 6;
        if (a < 0) a = 0;
        if (b > 1023) b = 1023;
        return $urandom_range(a, b);
    endfunction

    function automatic bit window_empty();
        return cur_left > cur_right || cur_top > cur_bottom;
    endfunction

    task automatic send_request(fb_request_t q);
        int gap;
        gap = draw_wait(s_calm);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= pack_request(q);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        mirror.note_request(q);
    endtask

    task automatic stop_stream();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // wait until every predicted result has come back, then let the engine settle
    task automatic drain();
        while (mirror.outstanding() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_register(logic [mbvs_pkg::CFG_AW-1:0] idx, int val);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= mbvs_pkg::CFG_DW'(val);
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        mirror.set_register(idx, mbvs_pkg::CFG_DW'(val));
    endtask

    task automatic set_window(int pitch, int l, int t, int r, int b);
        stop_stream();
        drain();
        write_register(mbvs_pkg::REG_ROW_BYTES, pitch);
        write_register(mbvs_pkg::REG_CLIP_LEFT, l);
        write_register(mbvs_pkg::REG_CLIP_TOP, t);
        write_register(mbvs_pkg::REG_CLIP_RIGHT, r);
        write_register(mbvs_pkg::REG_CLIP_BOTTOM, b);
        cur_pitch  = pitch;
        cur_left   = l;
        cur_top    = t;
        cur_right  = r;
        cur_bottom = b;
    endtask

    task automatic write_byte(int addr, int data);
        written_list.push_back(addr);
        send_request(make_request(mbvs_pkg::MODE_WRITE, addr, data, $urandom_range(0, 1023),
                                  $urandom_range(0, 1023), $urandom_range(0, 1024),
                                  $urandom_range(0, 1024), $urandom_range(0, 1023)));
    endtask

    // every byte a clipped scroll can touch gets written before any scroll runs
    task automatic fill_window();
        int          y, b;
        int unsigned addr;
        if (window_empty()) return;
        for (y = cur_top; y <= cur_bottom; y++) begin
            for (b = cur_left >> 3; b <= (cur_right >> 3); b++) begin
                addr = (y * cur_pitch + b) % mbvs_pkg::MEM_DEPTH;
                if (!mirror.written[addr]) write_byte(addr, $urandom_range(0, 255));
            end
        end
    endtask

    task automatic run_random(int count);
        fb_request_t q;
        int          pick, span_x, span_y;
        repeat (count) begin
            q    = random_fields();
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                q.mode = mbvs_pkg::MODE_SCROLL;
                // most scrolls aim at the clip window, the rest stay fully random
                if ($urandom_range(0, 3) != 0) begin
                    span_x = (cur_right > cur_left ? cur_right - cur_left
                                                   : cur_left - cur_right) + 1;
                    span_y = (cur_bottom > cur_top ? cur_bottom - cur_top
                                                   : cur_top - cur_bottom) + 1;
                    q.src_x       = 10'(near_range(cur_left, cur_right));
                    q.src_y       = 10'(near_range(cur_top, cur_bottom));
                    q.dst_y       = 10'(near_range(cur_top, cur_bottom));
                    q.rect_width  = 11'($urandom_range(0, span_x + 12 > 1024 ? 1024
                                                                             : span_x + 12));
                    q.rect_height = 11'($urandom_range(0, span_y + 4 > 1024 ? 1024
                                                                            : span_y + 4));
                    if ($urandom_range(0, 7) == 0) q.dst_y = q.src_y;
                end
            end else if (pick < 75) begin
                q.mode = mbvs_pkg::MODE_WRITE;
                if (!window_empty() && $urandom_range(0, 1) == 1) begin
                    q.byte_addr = 17'(($urandom_range(cur_top, cur_bottom) * cur_pitch
                                       + $urandom_range(cur_left >> 3, cur_right >> 3))
                                      % mbvs_pkg::MEM_DEPTH);
                end
                written_list.push_back(q.byte_addr);
            end else if (pick < 95 && written_list.size() > 0) begin
                q.mode      = mbvs_pkg::MODE_READ;
                q.byte_addr = 17'(written_list[$urandom_range(0, written_list.size() - 1)]);
            end else begin
                q.mode = mbvs_pkg::MODE_NONE;
            end
            send_request(q);
        end
    endtask

    // result side: random back-pressure, every accepted result goes to the checker
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        m_calm   = 0;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_wait(m_calm);
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            mirror.check_result(m_tdata);
        end
    end

    // watchdog: too long without any transaction on either stream ends the run
    initial idle_cycles = 0;
    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        mirror    = new();
        aresetn   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_calm    = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset defaults: byte access at the address extremes, unused mode, trivial scrolls
        cur_pitch  = 80;
        cur_left   = 0;
        cur_top    = 0;
        cur_right  = 1023;
        cur_bottom = 1023;
        write_byte(0, 8'h00);
        write_byte(mbvs_pkg::MEM_DEPTH - 1, 8'hFF);
        write_byte(17'h0AAAA, 8'h5A);
        write_byte(17'h15555, 8'hA5);
        send_request(make_request(mbvs_pkg::MODE_READ, mbvs_pkg::MEM_DEPTH - 1,
                                  0, 0, 0, 0, 0, 0));
        send_request(make_request(mbvs_pkg::MODE_READ, 0, 255, 1023, 1023, 1024, 1024, 1023));
        send_request(make_request(mbvs_pkg::MODE_READ, 17'h0AAAA, 0, 0, 0, 0, 0, 0));
        send_request(make_request(mbvs_pkg::MODE_READ, 17'h15555, 0, 0, 0, 0, 0, 0));
        send_request(make_request(mbvs_pkg::MODE_NONE, mbvs_pkg::MEM_DEPTH - 1,
                                  255, 1023, 1023, 1024, 1024, 1023));
        // same source and destination row
        send_request(make_request(mbvs_pkg::MODE_SCROLL, 0, 0, 0, 1023, 1024, 1024, 1023));
        // zero width
        send_request(make_request(mbvs_pkg::MODE_SCROLL, 0, 0, 0, 0, 0, 1024, 5));
        // zero height
        send_request(make_request(mbvs_pkg::MODE_SCROLL, 0, 0, 10, 3, 64, 0, 9));

        // narrow pitch, window with partial edge bytes on both sides
        set_window(4, 3, 2, 45, 9);
        fill_window();
        // columns cut away on the left
        send_request(make_request(mbvs_pkg::MODE_SCROLL, 0, 0, 0, 2, 3, 4, 5));
        // starts right of the window
        send_request(make_request(mbvs_pkg::MODE_SCROLL, 0, 0, 46, 2, 10, 4, 5));
        // source below the window bottom
        send_request(make_request(mbvs_pkg::MODE_SCROLL, 0, 0, 8, 10, 8, 5, 3));
        // rows entirely above the window top
        send_request(make_request(mbvs_pkg::MODE_SCROLL, 0, 0, 8, 0, 8, 2, 4));
        // largest rectangle, destination off the bottom
        send_request(make_request(mbvs_pkg::MODE_SCROLL, 0, 0, 0, 0, 1024, 1024, 1023));
        // largest rectangle clipped on all sides, moving down over itself
        send_request(make_request(mbvs_pkg::MODE_SCROLL, 0, 0, 0, 0, 1024, 1024, 3));
        // moving up, height cut at the bottom
        send_request(make_request(mbvs_pkg::MODE_SCROLL, 0, 0, 5, 7, 30, 1024, 2));
        // single pixel
        send_request(make_request(mbvs_pkg::MODE_SCROLL, 0, 0, 20, 4, 1, 1, 8));
        run_random(60);

        // one byte per row: rows alias heavily
        set_window(1, 0, 0, 23, 7);
        fill_window();
        run_random(40);

        // widest pitch, window in the far corner so addresses reach the top of memory
        set_window(128, 1010, 1016, 1023, 1023);
        fill_window();
        run_random(45);

        // whole bytes from the left edge, columns fit inside the pitch
        set_window(16, 0, 0, 63, 5);
        fill_window();
        run_random(45);

        // empty clip window: every scroll must be skipped
        set_window(128, 1023, 1023, 0, 0);
        run_random(15);

        stop_stream();
        drain();
        repeat (SETTLE) @(posedge aclk);

        $display("run covered %0d writes, %0d reads, %0d unused-mode transactions",
                 mirror.n_writes, mirror.n_reads, mirror.n_unused);
        $display("scrolls: %0d copied, %0d skipped, over six pitch and clip settings",
                 mirror.n_copied, mirror.n_skipped);
        if (mirror.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
